@@ src/fbpa_pkg.sv @@
// Shared types and constants for the fixed block pool allocator.
package fbpa_pkg;

    localparam int CNT_W      = 11;             // chunk count and used count width
    localparam int SIZE_W     = 13;             // chunk size register width
    localparam int OFF_W      = 22;             // byte offset width
    localparam int LIMIT_W    = CNT_W + SIZE_W; // count * size
    localparam int STEP_W     = $clog2(CNT_W);  // divider step counter
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [CNT_W-1:0]  RST_CHUNK_COUNT = CNT_W'(1024);
    localparam logic [SIZE_W-1:0] RST_CHUNK_SIZE  = SIZE_W'(64);
    localparam logic [SIZE_W-1:0] MIN_CHUNK_BYTES = SIZE_W'(4);
    localparam logic [CNT_W-1:0]  USED_MAX        = '1;

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_BAD   = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHUNK_COUNT = 1'b0,
        CFG_CHUNK_SIZE  = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ALLOC_POP,
        S_REL_DIV,
        S_REL_FIN
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load_alloc;   // pick the chunk, start link read
        logic load_rel;     // latch offset, start divider
        logic alloc_fin;    // pop head, form granted offset
        logic div_step;     // one quotient bit
        logic rel_fin;      // check and push
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic div_last;
    } t_stat;

endpackage

@@ src/fbpa_ctrl.sv @@
// Sequencing state machine of the fixed block pool allocator.
module fbpa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              i_opcode,
    input  fbpa_pkg::t_stat   i_stat,
    output fbpa_pkg::t_cmd    o_cmd,
    output logic              busy,
    output logic              o_done
);

    fbpa_pkg::t_state r_state, n_state;
    logic             r_done, n_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fbpa_pkg::S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        o_cmd   = '0;
        case (r_state)
            fbpa_pkg::S_IDLE: begin
                if (start) begin
                    if (fbpa_pkg::t_opcode'(i_opcode) == fbpa_pkg::OP_ALLOC) begin
                        o_cmd.load_alloc = 1'b1;
                        n_state          = fbpa_pkg::S_ALLOC_POP;
                    end else begin
                        o_cmd.load_rel = 1'b1;
                        n_state        = fbpa_pkg::S_REL_DIV;
                    end
                end
            end
            fbpa_pkg::S_ALLOC_POP: begin
                o_cmd.alloc_fin = 1'b1;
                n_done          = 1'b1;
                n_state         = fbpa_pkg::S_IDLE;
            end
            fbpa_pkg::S_REL_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = fbpa_pkg::S_REL_FIN;
                end
            end
            fbpa_pkg::S_REL_FIN: begin
                o_cmd.rel_fin = 1'b1;
                n_done        = 1'b1;
                n_state       = fbpa_pkg::S_IDLE;
            end
            default: begin
                n_state = fbpa_pkg::S_IDLE;
            end
        endcase
    end

    assign busy   = (r_state != fbpa_pkg::S_IDLE);
    assign o_done = r_done;

endmodule

@@ src/fbpa_dp.sv @@
// Datapath: config, free list state, link memory, divider and result registers.
module fbpa_dp #(
    parameter int unsigned MAX_CHUNKS      = 1024,
    parameter int unsigned MAX_CHUNK_BYTES = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fbpa_pkg::t_cmd                      i_cmd,
    output fbpa_pkg::t_stat                     o_stat,
    input  logic                                i_cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [fbpa_pkg::OFF_W-1:0]          i_release_offset,
    output logic [1:0]                          o_status,
    output logic [fbpa_pkg::OFF_W-1:0]          o_granted_offset,
    output logic [fbpa_pkg::CNT_W-1:0]          o_used_count
);

    localparam int HEAD_W = $clog2(MAX_CHUNKS + 1);
    localparam int IDX_W  = $clog2(MAX_CHUNKS);
    localparam logic [HEAD_W-1:0] EMPTY_MARK = HEAD_W'(MAX_CHUNKS);

    localparam int CNT_W   = fbpa_pkg::CNT_W;
    localparam int SIZE_W  = fbpa_pkg::SIZE_W;
    localparam int OFF_W   = fbpa_pkg::OFF_W;
    localparam int LIMIT_W = fbpa_pkg::LIMIT_W;
    localparam int STEP_W  = fbpa_pkg::STEP_W;

    // config and free list state
    logic [CNT_W-1:0]   r_count_raw;
    logic [SIZE_W-1:0]  r_size_raw;
    logic [HEAD_W-1:0]  r_head;
    logic [CNT_W-1:0]   r_fresh;
    logic [CNT_W-1:0]   r_in_use;

    logic [HEAD_W-1:0]  link_mem [MAX_CHUNKS];
    logic [HEAD_W-1:0]  r_link_rd;

    // request work registers
    logic [CNT_W-1:0]   r_idx;
    logic               r_got;
    logic               r_from_head;
    logic [OFF_W-1:0]   r_offset;
    logic [OFF_W-1:0]   r_rem;
    logic [LIMIT_W-1:0] r_dsh;
    logic [CNT_W-1:0]   r_quo;
    logic [STEP_W-1:0]  r_step;
    logic [LIMIT_W-1:0] r_limit;

    // result words
    fbpa_pkg::t_status  r_status;
    logic [OFF_W-1:0]   r_granted;
    logic [CNT_W-1:0]   r_used_out;

    logic [CNT_W-1:0]   eff_count;
    logic [SIZE_W-1:0]  eff_size;
    logic               head_valid;
    logic [LIMIT_W-1:0] rem_ext;
    logic               rem_ge;
    logic [LIMIT_W-1:0] grant_prod;
    logic               rel_bad;

    always_comb begin
        eff_count = r_count_raw;
        if (r_count_raw == '0) begin
            eff_count = CNT_W'(1);
        end else if (32'(r_count_raw) > MAX_CHUNKS) begin
            eff_count = CNT_W'(MAX_CHUNKS);
        end
        eff_size = r_size_raw;
        if (r_size_raw < fbpa_pkg::MIN_CHUNK_BYTES) begin
            eff_size = fbpa_pkg::MIN_CHUNK_BYTES;
        end else if (32'(r_size_raw) > MAX_CHUNK_BYTES) begin
            eff_size = SIZE_W'(MAX_CHUNK_BYTES);
        end
    end

    assign head_valid  = (r_head != EMPTY_MARK);
    assign rem_ext     = LIMIT_W'(r_rem);
    assign rem_ge      = (rem_ext >= r_dsh);
    assign grant_prod  = LIMIT_W'(r_idx) * LIMIT_W'(eff_size);
    assign rel_bad     = (LIMIT_W'(r_offset) >= r_limit) || (r_rem != '0);
    assign o_stat.div_last = (r_step == '0);

    // link memory: one write port, registered read of the current head
    always_ff @(posedge i_clk) begin
        if (i_cmd.rel_fin && !rel_bad) begin
            link_mem[IDX_W'(r_quo)] <= r_head;
        end
        r_link_rd <= link_mem[IDX_W'(r_head)];
    end

    // divider and request registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_alloc) begin
            r_from_head <= head_valid;
            r_got       <= head_valid || (r_fresh < eff_count);
            r_idx       <= head_valid ? CNT_W'(r_head) : r_fresh;
        end
        if (i_cmd.load_rel) begin
            r_offset <= i_release_offset;
            r_rem    <= i_release_offset;
            r_dsh    <= LIMIT_W'(eff_size) << (CNT_W - 1);
            r_quo    <= '0;
            r_step   <= STEP_W'(CNT_W - 1);
            r_limit  <= LIMIT_W'(eff_count) * LIMIT_W'(eff_size);
        end
        if (i_cmd.div_step) begin
            // restoring division, quotient fits CNT_W bits when offset is in range
            if (rem_ge) begin
                r_rem <= OFF_W'(rem_ext - r_dsh);
            end
            r_quo  <= {r_quo[CNT_W-2:0], rem_ge};
            r_dsh  <= r_dsh >> 1;
            r_step <= r_step - STEP_W'(1);
        end
    end

    // free list state and result words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_raw <= fbpa_pkg::RST_CHUNK_COUNT;
            r_size_raw  <= fbpa_pkg::RST_CHUNK_SIZE;
            r_head      <= EMPTY_MARK;
            r_fresh     <= '0;
            r_in_use    <= '0;
        end else begin
            if (i_cmd.load_alloc && !head_valid && (r_fresh < eff_count)) begin
                r_fresh <= r_fresh + CNT_W'(1);
            end
            if (i_cmd.alloc_fin) begin
                if (r_from_head) begin
                    r_head <= r_link_rd;
                end
                if (r_got && (r_in_use != fbpa_pkg::USED_MAX)) begin
                    r_in_use <= r_in_use + CNT_W'(1);
                end
            end
            if (i_cmd.rel_fin && !rel_bad) begin
                r_head <= HEAD_W'(r_quo);
                if (r_in_use != '0) begin
                    r_in_use <= r_in_use - CNT_W'(1);
                end
            end
            // a config write reinitializes the free list
            if (i_cfg_we) begin
                case (fbpa_pkg::t_cfg_idx'(i_cfg_idx))
                    fbpa_pkg::CFG_CHUNK_COUNT: r_count_raw <= i_cfg_data[CNT_W-1:0];
                    fbpa_pkg::CFG_CHUNK_SIZE:  r_size_raw  <= i_cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
                r_head   <= EMPTY_MARK;
                r_fresh  <= '0;
                r_in_use <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc_fin) begin
            r_status   <= r_got ? fbpa_pkg::ST_OK : fbpa_pkg::ST_EMPTY;
            r_granted  <= r_got ? grant_prod[OFF_W-1:0] : '0;
            r_used_out <= (r_got && (r_in_use != fbpa_pkg::USED_MAX))
                        ? r_in_use + CNT_W'(1) : r_in_use;
        end
        if (i_cmd.rel_fin) begin
            r_status   <= rel_bad ? fbpa_pkg::ST_BAD : fbpa_pkg::ST_OK;
            r_granted  <= '0;
            r_used_out <= (!rel_bad && (r_in_use != '0)) ? r_in_use - CNT_W'(1) : r_in_use;
        end
    end

    assign o_status         = r_status;
    assign o_granted_offset = r_granted;
    assign o_used_count     = r_used_out;

endmodule

@@ src/fixed_block_pool_allocator.sv @@
// Top level of the fixed block pool allocator: controller plus datapath.
//
//  channel   handshake               word
//  -------   ---------------------   ------------------------------------------
//  request   start & !busy           i_opcode, i_release_offset
//  result    o_done (one cycle)      o_status, o_granted_offset, o_used_count
//  config    i_cfg_we                i_cfg_idx, i_cfg_data
//
// Allocate: S_ALLOC_POP registers o_done and the result words, then returns to S_IDLE.
// Release: 11-step restoring divider (offset / chunk size) in S_REL_DIV sets the pace;
// S_REL_FIN then registers o_done and the result. New requests are taken only in S_IDLE.
// Reset (i_rst_n low, synchronous) empties the pool state; count 1024, size 64.
// The result is shown for exactly one cycle; the receiver cannot stall it.
module fixed_block_pool_allocator #(
    parameter int unsigned MAX_CHUNKS      = 1024,
    parameter int unsigned MAX_CHUNK_BYTES = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_opcode,
    input  logic [fbpa_pkg::OFF_W-1:0]          i_release_offset,
    output logic                                o_done,
    output logic [1:0]                          o_status,
    output logic [fbpa_pkg::OFF_W-1:0]          o_granted_offset,
    output logic [fbpa_pkg::CNT_W-1:0]          o_used_count,
    input  logic                                i_cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    fbpa_pkg::t_cmd  cmd;
    fbpa_pkg::t_stat stat;

    fbpa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_opcode (i_opcode),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .busy     (busy),
        .o_done   (o_done)
    );

    fbpa_dp #(
        .MAX_CHUNKS      (MAX_CHUNKS),
        .MAX_CHUNK_BYTES (MAX_CHUNK_BYTES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_release_offset (i_release_offset),
        .o_status         (o_status),
        .o_granted_offset (o_granted_offset),
        .o_used_count     (o_used_count)
    );

endmodule

@@ tb/sv/fbpa_checker.sv @@
// Scoreboard for the fixed block pool allocator: free-list predictor and result compare.
module fbpa_checker
    import fbpa_pkg::*;
#(
    parameter int unsigned MAX_CHUNKS      = 1024,
    parameter int unsigned MAX_CHUNK_BYTES = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic                  i_opcode,
    input  logic [OFF_W-1:0]      i_release_offset,
    input  logic                  i_done,
    input  logic [1:0]            i_status,
    input  logic [OFF_W-1:0]      i_granted_offset,
    input  logic [CNT_W-1:0]      i_used_count,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_ok_count,
    output int                    o_empty_count,
    output int                    o_bad_count
);

    typedef struct packed {
        t_status          status;
        logic [OFF_W-1:0] offset;
        logic [CNT_W-1:0] used;
    } t_pool_reply;

    logic [CNT_W-1:0]  link_mem [MAX_CHUNKS];
    logic [CNT_W-1:0]  stack_top;   // last released chunk, MAX_CHUNKS when none
    logic [CNT_W-1:0]  fresh_next;  // chunks from here up never handed out
    logic [CNT_W-1:0]  held;
    logic [CNT_W-1:0]  count_reg;
    logic [SIZE_W-1:0] size_reg;
    t_pool_reply       reply_q[$];
    int                fails   = 0;
    int                n_ok    = 0;
    int                n_empty = 0;
    int                n_bad   = 0;

    function automatic int unsigned pool_chunks();
        if (count_reg == '0) return 1;
        if (32'(count_reg) > MAX_CHUNKS) return MAX_CHUNKS;
        return 32'(count_reg);
    endfunction

    function automatic int unsigned chunk_bytes();
        if (size_reg < MIN_CHUNK_BYTES) return 32'(MIN_CHUNK_BYTES);
        if (32'(size_reg) > MAX_CHUNK_BYTES) return MAX_CHUNK_BYTES;
        return 32'(size_reg);
    endfunction

    function automatic void reinit_pool();
        stack_top  = CNT_W'(MAX_CHUNKS);
        fresh_next = '0;
        held       = '0;
    endfunction

    // Applies one request to the free list and returns the reply it should give.
    function automatic t_pool_reply serve(t_opcode op, logic [OFF_W-1:0] off);
        int unsigned     chunks;
        int unsigned     bytes;
        int unsigned     idx;
        longint unsigned span;
        t_pool_reply     r;
        chunks   = pool_chunks();
        bytes    = chunk_bytes();
        idx      = 0;
        r.status = ST_OK;
        r.offset = '0;
        if (op == OP_ALLOC) begin
            if (32'(stack_top) < MAX_CHUNKS) begin
                idx       = 32'(stack_top);
                stack_top = link_mem[idx];
            end else if (32'(fresh_next) < chunks) begin
                idx        = 32'(fresh_next);
                fresh_next = fresh_next + CNT_W'(1);
            end else begin
                r.status = ST_EMPTY;
            end
            if (r.status == ST_OK) begin
                r.offset = OFF_W'(idx * bytes);
                if (held != USED_MAX) held = held + CNT_W'(1);
            end
        end else begin
            span = 64'(chunks) * 64'(bytes);
            if (64'(off) >= span || (32'(off) % bytes) != 0) begin
                r.status = ST_BAD;
            end else begin
                // no double-release check: a free chunk is pushed again
                idx           = 32'(off) / bytes;
                link_mem[idx] = stack_top;
                stack_top     = CNT_W'(idx);
                if (held != '0) held = held - CNT_W'(1);
            end
        end
        r.used = held;
        return r;
    endfunction

    always @(posedge i_clk) begin : track
        t_pool_reply want;
        if (!i_rst_n) begin
            count_reg = RST_CHUNK_COUNT;
            size_reg  = RST_CHUNK_SIZE;
            reinit_pool();
            reply_q.delete();
        end else begin
            if (i_done) begin
                if (reply_q.size() == 0) begin
                    $display("%0t: unexpected word, status %0d offset %0d used %0d", $time,
                             i_status, i_granted_offset, i_used_count);
                    fails++;
                end else begin
                    want = reply_q.pop_front();
                    if (i_status !== want.status) begin
                        $display("%0t: status expected %0d, got %0d", $time, want.status,
                                 i_status);
                        fails++;
                    end
                    if (i_granted_offset !== want.offset) begin
                        $display("%0t: granted offset expected %0d, got %0d", $time,
                                 want.offset, i_granted_offset);
                        fails++;
                    end
                    if (i_used_count !== want.used) begin
                        $display("%0t: used count expected %0d, got %0d", $time, want.used,
                                 i_used_count);
                        fails++;
                    end
                    case (want.status)
                        ST_OK:    n_ok++;
                        ST_EMPTY: n_empty++;
                        default:  n_bad++;
                    endcase
                end
            end
            if (i_cfg_we) begin
                if (t_cfg_idx'(i_cfg_idx) == CFG_CHUNK_COUNT) begin
                    count_reg = i_cfg_data[CNT_W-1:0];
                    reinit_pool();
                end else if (t_cfg_idx'(i_cfg_idx) == CFG_CHUNK_SIZE) begin
                    size_reg = i_cfg_data;
                    reinit_pool();
                end
            end
            if (i_start && !i_busy)
                reply_q.push_back(serve(t_opcode'(i_opcode), i_release_offset));
        end
        o_pending     <= reply_q.size();
        o_fail_count  <= fails;
        o_ok_count    <= n_ok;
        o_empty_count <= n_empty;
        o_bad_count   <= n_bad;
    end

endmodule

@@ tb/sv/tb_fixed_block_pool_allocator.sv @@
// Testbench top for the fixed block pool allocator: reset, register setup and request stimulus.
module tb_fixed_block_pool_allocator;
    import fbpa_pkg::*;

    localparam int unsigned MAX_CHUNKS      = 1024;
    localparam int unsigned MAX_CHUNK_BYTES = 4096;
    localparam int          CYCLE_LIMIT     = 400000;
    localparam int          RANDOM_WORDS    = 340;
    localparam int          LOOP_ALLOCS     = 20;

    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  start            = 1'b0;
    logic                  busy;
    logic                  i_opcode         = 1'b0;
    logic [OFF_W-1:0]      i_release_offset = '0;
    logic                  o_done;
    logic [1:0]            o_status;
    logic [OFF_W-1:0]      o_granted_offset;
    logic [CNT_W-1:0]      o_used_count;
    logic                  i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx        = CFG_CHUNK_COUNT;
    logic [CFG_DATA_W-1:0] i_cfg_data       = '0;

    int fail_count;
    int pending_words;
    int ok_count;
    int empty_count;
    int bad_count;
    int cycles     = 0;
    int sent       = 0;
    int reg_writes = 0;
    int burst_left = 0;
    bit steady     = 1'b0;

    // effective pool shape, used only to aim release offsets
    int unsigned      pool_chunks = 1024;
    int unsigned      pool_bytes  = 64;
    logic [OFF_W-1:0] granted_list[$];
    t_opcode          inflight_ops[$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    fixed_block_pool_allocator #(
        .MAX_CHUNKS      (MAX_CHUNKS),
        .MAX_CHUNK_BYTES (MAX_CHUNK_BYTES)
    ) uut (.*);

    fbpa_checker #(
        .MAX_CHUNKS      (MAX_CHUNKS),
        .MAX_CHUNK_BYTES (MAX_CHUNK_BYTES)
    ) checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_opcode         (i_opcode),
        .i_release_offset (i_release_offset),
        .i_done           (o_done),
        .i_status         (o_status),
        .i_granted_offset (o_granted_offset),
        .i_used_count     (o_used_count),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending_words),
        .o_ok_count       (ok_count),
        .o_empty_count    (empty_count),
        .o_bad_count      (bad_count)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("fixed_block_pool_allocator: mismatch");
            $finish;
        end
    end

    // Mid-cycle snoop of handed-out chunks so later releases can target them.
    always @(negedge i_clk) begin
        if (o_done && inflight_ops.size() != 0) begin
            if (inflight_ops.pop_front() == OP_ALLOC && o_status == ST_OK)
                granted_list.push_back(o_granted_offset);
        end
        if (i_rst_n && start && !busy) inflight_ops.push_back(t_opcode'(i_opcode));
    end

    task automatic pace();
        int gap;
        if (steady) return;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    task automatic issue(input t_opcode op, input logic [OFF_W-1:0] off);
        pace();
        start            <= 1'b1;
        i_opcode         <= op;
        i_release_offset <= off;
        do @(posedge i_clk); while (busy);
        sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_words != 0 || busy);
    endtask

    // Writes both registers back to back; each write restarts the free list.
    task automatic program_pool(input logic [CFG_DATA_W-1:0] count_data,
                                input logic [CFG_DATA_W-1:0] size_data);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_CHUNK_COUNT;
        i_cfg_data <= count_data;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_CHUNK_SIZE;
        i_cfg_data <= size_data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        reg_writes += 2;
        pool_chunks = (count_data[CNT_W-1:0] == '0) ? 1 :
                      (32'(count_data[CNT_W-1:0]) > MAX_CHUNKS) ? MAX_CHUNKS :
                      32'(count_data[CNT_W-1:0]);
        pool_bytes  = (size_data < MIN_CHUNK_BYTES) ? 32'(MIN_CHUNK_BYTES) :
                      (32'(size_data) > MAX_CHUNK_BYTES) ? MAX_CHUNK_BYTES :
                      32'(size_data);
        granted_list.delete();
        burst_left = 0;
    endtask

    initial begin
        int                    r;
        int                    n;
        int                    pick;
        int                    random_sent;
        logic [OFF_W-1:0]      off;
        logic [CFG_DATA_W-1:0] cnt_data;
        logic [CFG_DATA_W-1:0] size_data;
        random_sent = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset shape: 1024 chunks of 64 bytes
        issue(OP_ALLOC, '0);
        issue(OP_ALLOC, '1);
        issue(OP_RELEASE, OFF_W'(64));
        issue(OP_RELEASE, OFF_W'(1));          // misaligned
        issue(OP_RELEASE, OFF_W'(65536));      // exactly at the end of the pool
        issue(OP_RELEASE, '1);
        issue(OP_RELEASE, OFF_W'(65472));      // last chunk, never handed out
        issue(OP_RELEASE, OFF_W'(0));          // used count already at zero
        issue(OP_ALLOC, '0);
        issue(OP_ALLOC, '0);

        // three big chunks: run dry, then reuse
        program_pool(CFG_DATA_W'(3), CFG_DATA_W'(4096));
        repeat (4) issue(OP_ALLOC, '0);
        issue(OP_RELEASE, OFF_W'(12288));
        issue(OP_RELEASE, OFF_W'(8191));
        issue(OP_RELEASE, OFF_W'(8192));
        issue(OP_ALLOC, '0);

        // zero count and zero size fall back to one chunk of 4 bytes
        program_pool('0, '0);
        issue(OP_ALLOC, '0);
        issue(OP_ALLOC, '0);
        issue(OP_RELEASE, OFF_W'(4));
        issue(OP_RELEASE, OFF_W'(0));

        // all-ones register data: count and size clamp to their maxima
        program_pool('1, '1);
        issue(OP_RELEASE, OFF_W'(4190208));
        issue(OP_RELEASE, '1);
        issue(OP_ALLOC, '0);
        issue(OP_ALLOC, '0);

        // double release of one chunk makes it its own successor; allocate
        // from it repeatedly past the pool size
        program_pool(CFG_DATA_W'(1), CFG_DATA_W'(4));
        issue(OP_RELEASE, '0);
        issue(OP_RELEASE, '0);
        steady = ($urandom_range(0, 1) == 0);
        for (int k = 0; k < LOOP_ALLOCS; k++) issue(OP_ALLOC, OFF_W'($urandom));

        while (random_sent < RANDOM_WORDS) begin
            case ($urandom_range(0, 7))
                0:       cnt_data = '0;
                1:       cnt_data = CFG_DATA_W'(1);
                2:       cnt_data = CFG_DATA_W'(MAX_CHUNKS);
                3:       cnt_data = CFG_DATA_W'($urandom);  // top bits dropped by the block
                default: cnt_data = CFG_DATA_W'($urandom_range(2, 12));
            endcase
            case ($urandom_range(0, 7))
                0:       size_data = CFG_DATA_W'($urandom_range(0, 3));
                1:       size_data = MIN_CHUNK_BYTES;
                2:       size_data = CFG_DATA_W'(MAX_CHUNK_BYTES);
                3:       size_data = CFG_DATA_W'($urandom_range(MAX_CHUNK_BYTES + 1, 8191));
                4:       size_data = CFG_DATA_W'($urandom);
                default: size_data = CFG_DATA_W'($urandom_range(4, 300));
            endcase
            program_pool(cnt_data, size_data);
            steady = ($urandom_range(0, 4) == 0);
            n = $urandom_range(20, 60);
            for (int k = 0; k < n; k++) begin
                r = $urandom_range(0, 99);
                if (r < 45 || (r < 80 && granted_list.size() == 0)) begin
                    issue(OP_ALLOC, OFF_W'($urandom));
                end else if (r < 80) begin
                    pick = $urandom_range(0, granted_list.size() - 1);
                    off  = granted_list[pick];
                    granted_list.delete(pick);
                    issue(OP_RELEASE, off);
                end else if (r < 87) begin
                    issue(OP_RELEASE,
                          OFF_W'($urandom_range(0, pool_chunks - 1) * pool_bytes));
                end else if (r < 91) begin
                    issue(OP_RELEASE,
                          OFF_W'($urandom_range(0, pool_chunks - 1) * pool_bytes +
                                 $urandom_range(1, pool_bytes - 1)));
                end else if (r < 95) begin
                    issue(OP_RELEASE,
                          OFF_W'((pool_chunks + $urandom_range(0, 3)) * pool_bytes));
                end else begin
                    issue(OP_RELEASE, OFF_W'($urandom));
                end
            end
            random_sent += n;
        end

        drain();
        repeat (20) @(posedge i_clk);

        $display("Sent %0d requests across %0d register writes:", sent, reg_writes);
        $display("  %0d ok, %0d pool empty, %0d bad offset; clamped shapes, LIFO reuse,",
                 ok_count, empty_count, bad_count);
        $display("  double release and the used count floor were exercised.");
        if (fail_count == 0)
            $display("fixed_block_pool_allocator: match");
        else
            $display("fixed_block_pool_allocator: mismatch");
        $finish;
    end

endmodule
